// File: hw/rtl/smpq_pkg.sv
// smpq_pkg: widths, codes and command/status structs for the stable min priority queue
// used by smpq_ctrl, smpq_datapath and stable_min_priority_queue; no dependencies
`default_nettype none

package smpq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 15;
  localparam int KEY_W    = 32;
  localparam int STS_W    = 2;
  localparam int OCC_W    = 7;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [STS_W-1:0] {
    STS_INSERTED = 2'd0,
    STS_REMOVED  = 2'd1,
    STS_EMPTY    = 2'd2,
    STS_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic             [ID_W-1:0]  task_id;
    logic signed      [KEY_W-1:0] key;
  } entry_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    capture;
    logic    load_j_count;
    logic    load_j_one;
    logic    dec_j;
    logic    write_new;
    logic    write_move;
    logic    pop;
    logic    set_status;
    status_e status;
    logic    load_out;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic j_zero;
    logic key_le;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/stable_min_priority_queue.sv
// stable_min_priority_queue: top level joining smpq_ctrl and smpq_datapath
// depends on smpq_pkg, smpq_ctrl, smpq_datapath
//
// channel   direction  handshake                 fields
// input     in         in_valid_i / in_stall_o   operation_i, task_id_i, key_i
// result    out        out_valid_o / out_stall_i status_o, removed_task_id_o, occupancy_o
//
// one item at a time; a remove passes through the pop and response states, a remove
// from empty or an insert into a full queue goes straight to the response state, and
// an insert is timed by its shift loop, one held entry with a larger key moved up per cycle
// through the single write port of the entry memory, read data registered
// reset clears the count, head and control state; the entry memory is not cleared
// the result sits in an output register, so a stalled result still lets the next
// transfer in; a new result waits in the response state while the old one is stalled
`default_nettype none

module stable_min_priority_queue (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               operation_i,
  input  wire logic        [smpq_pkg::ID_W-1:0]   task_id_i,
  input  wire logic signed [smpq_pkg::KEY_W-1:0]  key_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic             [smpq_pkg::STS_W-1:0]  status_o,
  output logic             [smpq_pkg::ID_W-1:0]   removed_task_id_o,
  output logic             [smpq_pkg::OCC_W-1:0]  occupancy_o
);

  smpq_pkg::dp_cmd_t  cmd;
  smpq_pkg::dp_stat_t stat;

  smpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  smpq_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .task_id_i         (task_id_i),
    .key_i             (key_i),
    .status_o          (status_o),
    .removed_task_id_o (removed_task_id_o),
    .occupancy_o       (occupancy_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/smpq_datapath.sv
// smpq_datapath: circular sorted entry memory, head and count registers, result registers
// depends on smpq_pkg; driven by commands from smpq_ctrl
`default_nettype none

module smpq_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire smpq_pkg::dp_cmd_t                  cmd_i,
  output smpq_pkg::dp_stat_t                      stat_o,
  input  wire logic        [smpq_pkg::ID_W-1:0]   task_id_i,
  input  wire logic signed [smpq_pkg::KEY_W-1:0]  key_i,
  output logic             [smpq_pkg::STS_W-1:0]  status_o,
  output logic             [smpq_pkg::ID_W-1:0]   removed_task_id_o,
  output logic             [smpq_pkg::OCC_W-1:0]  occupancy_o
);

  localparam int IDX_W = smpq_pkg::IDX_W;
  localparam int CNT_W = smpq_pkg::CNT_W;

  smpq_pkg::entry_t mem [smpq_pkg::CAPACITY];
  smpq_pkg::entry_t rdata_q;
  smpq_pkg::entry_t new_q;

  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] rd_lidx;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             mem_we;
  smpq_pkg::entry_t wdata;

  smpq_pkg::status_e                pend_status_q;
  logic [smpq_pkg::ID_W-1:0]        pend_id_q;
  logic [smpq_pkg::STS_W-1:0]       out_status_q;
  logic [smpq_pkg::ID_W-1:0]        out_id_q;
  logic [smpq_pkg::OCC_W-1:0]       out_occ_q;

  // logical slot to physical slot, wrapping at the capacity
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] lidx);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, lidx};
    if (sum >= (IDX_W+1)'(smpq_pkg::CAPACITY)) begin
      sum = sum - (IDX_W+1)'(smpq_pkg::CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  always_comb begin
    j_d = j_q;
    if (cmd_i.load_j_count) begin
      j_d = count_q[IDX_W-1:0];
    end else if (cmd_i.load_j_one) begin
      j_d = IDX_W'(1);
    end else if (cmd_i.dec_j) begin
      j_d = j_q - IDX_W'(1);
    end
  end

  // read the slot just below the next write position; the read data is registered
  assign rd_lidx = (j_d == '0) ? '0 : j_d - IDX_W'(1);
  assign rd_idx  = phys(head_q, rd_lidx);
  assign wr_idx  = phys(head_q, j_q);
  assign mem_we  = cmd_i.write_new | cmd_i.write_move;
  assign wdata   = cmd_i.write_new ? new_q : rdata_q;

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.write_new) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.pop) begin
      count_d = count_q - CNT_W'(1);
      head_d  = (head_q == IDX_W'(smpq_pkg::CAPACITY - 1)) ? '0 : head_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      j_q     <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_idx] <= wdata;
    end
    rdata_q <= mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      new_q.task_id <= task_id_i;
      new_q.key     <= key_i;
    end
    if (cmd_i.set_status) begin
      pend_status_q <= cmd_i.status;
      pend_id_q     <= cmd_i.pop ? rdata_q.task_id : '0;
    end
    if (cmd_i.load_out) begin
      out_status_q <= pend_status_q;
      out_id_q     <= pend_id_q;
      out_occ_q    <= smpq_pkg::OCC_W'(count_q);
    end
  end

  assign stat_o.empty  = (count_q == '0);
  assign stat_o.full   = (count_q == CNT_W'(smpq_pkg::CAPACITY));
  assign stat_o.j_zero = (j_q == '0);
  // equal keys stay below the new entry, which keeps the order stable
  assign stat_o.key_le = (rdata_q.key <= new_q.key);

  assign status_o          = out_status_q;
  assign removed_task_id_o = out_id_q;
  assign occupancy_o       = out_occ_q;

endmodule

`default_nettype wire

// File: hw/rtl/smpq_ctrl.sv
// smpq_ctrl: sequencing state machine and output valid for the priority queue
// depends on smpq_pkg; commands smpq_datapath
`default_nettype none

module smpq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               operation_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire smpq_pkg::dp_stat_t stat_i,
  output smpq_pkg::dp_cmd_t       cmd_o
);

  smpq_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             slot_free;
  logic             scan_done;

  assign accept    = in_valid_i && (state_q == smpq_pkg::ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign scan_done = stat_i.j_zero || stat_i.key_le;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smpq_pkg::ST_IDLE: begin
        if (accept) begin
          if (operation_i == smpq_pkg::OP_INSERT) begin
            state_d = stat_i.full ? smpq_pkg::ST_RESP : smpq_pkg::ST_SCAN;
          end else begin
            state_d = stat_i.empty ? smpq_pkg::ST_RESP : smpq_pkg::ST_POP;
          end
        end
      end
      smpq_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = smpq_pkg::ST_RESP;
        end
      end
      smpq_pkg::ST_POP: begin
        state_d = smpq_pkg::ST_RESP;
      end
      smpq_pkg::ST_RESP: begin
        if (slot_free) begin
          state_d = smpq_pkg::ST_IDLE;
        end
      end
      default: state_d = smpq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.status = smpq_pkg::STS_INSERTED;
    in_stall_o  = (state_q != smpq_pkg::ST_IDLE);
    unique case (state_q)
      smpq_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          if (operation_i == smpq_pkg::OP_INSERT) begin
            if (stat_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = smpq_pkg::STS_FULL;
            end else begin
              cmd_o.load_j_count = 1'b1;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = smpq_pkg::STS_EMPTY;
            end else begin
              cmd_o.load_j_one = 1'b1;
            end
          end
        end
      end
      smpq_pkg::ST_SCAN: begin
        // shift larger keys up one slot until the new entry finds its place
        if (scan_done) begin
          cmd_o.write_new  = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = smpq_pkg::STS_INSERTED;
        end else begin
          cmd_o.write_move = 1'b1;
          cmd_o.dec_j      = 1'b1;
        end
      end
      smpq_pkg::ST_POP: begin
        cmd_o.pop        = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = smpq_pkg::STS_REMOVED;
      end
      smpq_pkg::ST_RESP: begin
        cmd_o.load_out = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smpq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
